// ----- hdl/lfulru_pkg.sv -----
// Shared types and constants for the LFU cache with LRU tie-break.
// No dependencies; used by lfulru_engine and the top level in hdl/.
package lfulru_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int USES_W = 32;
  localparam int AGE_W  = SLOT_W;
  localparam int CAP_W  = 5;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } state_t;

  // One cache slot as held in the slot RAM.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [USES_W-1:0] uses;
    logic [AGE_W-1:0]  age;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Write request into the slot RAM.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } ram_wr_t;

endpackage

// ----- hdl/lfulru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfulru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lfulru_engine.sv -----
// Request sequencer: scan pass, decision, age-update pass over the slot RAM.
// Depends on lfulru_pkg; drives an external lfulru_ram instance.
module lfulru_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             func,
  input  logic signed [31:0]               lookup_key,
  input  logic signed [31:0]               store_value,
  input  logic [lfulru_pkg::CNT_W-1:0]     cap_eff,
  output logic                             busy,
  output logic                             done,
  output logic                             hit,
  output logic signed [31:0]               read_value,
  output logic [lfulru_pkg::SLOT_W-1:0]    ram_raddr,
  input  lfulru_pkg::slot_entry_t          ram_rdata,
  output lfulru_pkg::ram_wr_t              ram_wr
);

  lfulru_pkg::state_t state, state_next;

  logic [lfulru_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                          rd_vld;
  logic [lfulru_pkg::SLOT_W-1:0] rd_slot;

  logic                          op_func;
  logic [lfulru_pkg::KEY_W-1:0]  op_key;
  logic [lfulru_pkg::DATA_W-1:0] op_value;

  logic                          m_found;
  logic [lfulru_pkg::SLOT_W-1:0] m_slot;
  logic [lfulru_pkg::DATA_W-1:0] m_data;
  logic [lfulru_pkg::USES_W-1:0] m_uses;
  logic [lfulru_pkg::AGE_W-1:0]  m_age;

  logic                          v_found;
  logic [lfulru_pkg::SLOT_W-1:0] v_slot;
  logic [lfulru_pkg::USES_W-1:0] v_uses;
  logic [lfulru_pkg::AGE_W-1:0]  v_age;

  logic [lfulru_pkg::SLOTS-1:0]  used;
  logic [lfulru_pkg::CNT_W-1:0]  entries;
  logic [lfulru_pkg::SLOT_W-1:0] tgt;
  logic                          ins_r;
  logic                          evict_r;

  logic                          done_next;
  logic                          hit_next;
  logic [31:0]                   read_value_next;

  // decision terms
  logic                          cap_zero;
  logic                          do_insert;
  logic                          do_evict;
  logic                          do_change;
  logic [lfulru_pkg::SLOTS-1:0]  used_post;
  logic [lfulru_pkg::SLOT_W-1:0] free_slot;
  logic [lfulru_pkg::SLOT_W-1:0] tgt_d;
  lfulru_pkg::slot_entry_t       tgt_entry;
  lfulru_pkg::slot_entry_t       upd_entry;
  logic                          scan_live;

  assign busy      = (state != lfulru_pkg::ST_IDLE);
  assign ram_raddr = cnt[lfulru_pkg::SLOT_W-1:0];
  assign scan_live = rd_vld && used[rd_slot];

  assign cap_zero  = (cap_eff == '0);
  assign do_insert = (op_func == lfulru_pkg::FUNC_PUT) && !m_found && !cap_zero;
  assign do_evict  = do_insert && (entries >= cap_eff) && v_found;
  assign do_change = ((op_func == lfulru_pkg::FUNC_GET) && m_found) ||
                     ((op_func == lfulru_pkg::FUNC_PUT) && !cap_zero);
  assign tgt_d     = m_found ? m_slot : free_slot;

  always_comb begin
    used_post = used;
    if (do_evict) begin
      used_post[v_slot] = 1'b0;
    end
    free_slot = '0;
    for (int i = lfulru_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_post[i]) begin
        free_slot = lfulru_pkg::SLOT_W'(i);
      end
    end
  end

  // Entry for the slot being used by this request.
  always_comb begin
    tgt_entry.key  = op_key;
    tgt_entry.data = (op_func == lfulru_pkg::FUNC_PUT) ? op_value : m_data;
    if (do_insert) begin
      tgt_entry.uses = lfulru_pkg::USES_W'(1);
    end else if (m_uses == '1) begin
      tgt_entry.uses = m_uses;
    end else begin
      tgt_entry.uses = m_uses + lfulru_pkg::USES_W'(1);
    end
    tgt_entry.age = '0;
  end

  // Age rework for the other used slots.
  always_comb begin
    upd_entry = ram_rdata;
    if (ins_r) begin
      upd_entry.age = ram_rdata.age + lfulru_pkg::AGE_W'(1)
                      - lfulru_pkg::AGE_W'(evict_r && (ram_rdata.age > v_age));
    end else begin
      upd_entry.age = ram_rdata.age
                      + lfulru_pkg::AGE_W'(ram_rdata.age < m_age);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfulru_pkg::ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    done_next       = 1'b0;
    hit_next        = m_found;
    read_value_next = '0;
    ram_wr          = '0;
    unique case (state)
      lfulru_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lfulru_pkg::ST_SCAN;
          cnt_next   = '0;
        end
      end
      lfulru_pkg::ST_SCAN: begin
        if (cnt == lfulru_pkg::CNT_W'(lfulru_pkg::SLOTS)) begin
          state_next = lfulru_pkg::ST_DECIDE;
        end else begin
          cnt_next = cnt + lfulru_pkg::CNT_W'(1);
        end
      end
      lfulru_pkg::ST_DECIDE: begin
        done_next = 1'b1;
        if (op_func == lfulru_pkg::FUNC_PUT) begin
          read_value_next = '0;
        end else if (m_found) begin
          read_value_next = m_data;
        end else begin
          read_value_next = '1;
        end
        cnt_next = '0;
        if (do_change) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = tgt_d;
          ram_wr.data = tgt_entry;
          state_next  = lfulru_pkg::ST_UPDATE;
        end else begin
          state_next = lfulru_pkg::ST_IDLE;
        end
      end
      lfulru_pkg::ST_UPDATE: begin
        if (rd_vld && used[rd_slot] && (rd_slot != tgt)) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = rd_slot;
          ram_wr.data = upd_entry;
        end
        if (cnt == lfulru_pkg::CNT_W'(lfulru_pkg::SLOTS)) begin
          state_next = lfulru_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + lfulru_pkg::CNT_W'(1);
        end
      end
      default: state_next = lfulru_pkg::ST_IDLE;
    endcase
  end

  // Valid bits and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      entries <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= ((state == lfulru_pkg::ST_SCAN) || (state == lfulru_pkg::ST_UPDATE)) &&
                (cnt < lfulru_pkg::CNT_W'(lfulru_pkg::SLOTS));
      if (state == lfulru_pkg::ST_DECIDE && do_insert) begin
        used          <= used_post | (lfulru_pkg::SLOTS'(1) << tgt_d);
        entries       <= entries + lfulru_pkg::CNT_W'(1) - lfulru_pkg::CNT_W'(do_evict);
      end
    end
  end

  // Request capture, scan results, output payload.
  always_ff @(posedge clk) begin
    rd_slot <= cnt[lfulru_pkg::SLOT_W-1:0];
    if (state == lfulru_pkg::ST_IDLE && start) begin
      op_func  <= func;
      op_key   <= lookup_key;
      op_value <= store_value;
      m_found  <= 1'b0;
      v_found  <= 1'b0;
    end
    if (state == lfulru_pkg::ST_SCAN && scan_live) begin
      if (ram_rdata.key == op_key) begin
        m_found <= 1'b1;
        m_slot  <= rd_slot;
        m_data  <= ram_rdata.data;
        m_uses  <= ram_rdata.uses;
        m_age   <= ram_rdata.age;
      end
      if (!v_found || (ram_rdata.uses < v_uses) ||
          ((ram_rdata.uses == v_uses) && (ram_rdata.age > v_age))) begin
        v_found <= 1'b1;
        v_slot  <= rd_slot;
        v_uses  <= ram_rdata.uses;
        v_age   <= ram_rdata.age;
      end
    end
    if (state == lfulru_pkg::ST_DECIDE) begin
      tgt     <= tgt_d;
      ins_r   <= do_insert;
      evict_r <= do_evict;
    end
    if (done_next) begin
      hit        <= hit_next;
      read_value <= read_value_next;
    end
  end

endmodule

// ----- hdl/lfu_cache_lru_tiebreak_top.sv -----
// Top level of the LFU key-value cache with LRU tie-break.
// Depends on lfulru_pkg, lfulru_ram and lfulru_engine.
//
// Channel    Ports                                      Handshake
// ---------  -----------------------------------------  ------------------------------
// request    func, lookup_key, store_value              taken when start & !busy
// result     hit, read_value                            valid for the one cycle of done
// config     capacity_in_use                            written when capacity_we is high
//
// A request that changes state runs a scan pass over the slot RAM, a decide
// state and an update pass before it returns to idle; a get miss or a put with
// capacity zero returns to idle from the decide state. Both passes are set by
// the single read port of the slot RAM. The result strobes out as the decide
// state ends. Reset clears the valid bits, the fill count and the capacity
// (to 16); RAM contents are not cleared. The result side cannot stall; the
// request side sees busy for the whole op.
module lfu_cache_lru_tiebreak_top (
  input  logic                          clk,
  input  logic                          rst,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic signed [31:0]            lookup_key,
  input  logic signed [31:0]            store_value,
  // result
  output logic                          done,
  output logic                          hit,
  output logic signed [31:0]            read_value,
  // configuration
  input  logic                          capacity_we,
  input  logic [lfulru_pkg::CAP_W-1:0]  capacity_in_use
);

  logic [lfulru_pkg::CAP_W-1:0]   capacity;
  logic [lfulru_pkg::CNT_W-1:0]   cap_eff;
  logic [lfulru_pkg::SLOT_W-1:0]  ram_raddr;
  lfulru_pkg::slot_entry_t        ram_rdata;
  logic [lfulru_pkg::ENTRY_W-1:0] ram_rdata_bits;
  lfulru_pkg::ram_wr_t            ram_wr;

  // Capacity register; reset value is a full cache of 16.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfulru_pkg::CAP_W'(16);
    end else if (capacity_we) begin
      capacity <= capacity_in_use;
    end
  end

  // Capacity above the slot count behaves as the slot count.
  always_comb begin
    if (32'(capacity) > 32'(lfulru_pkg::SLOTS)) begin
      cap_eff = lfulru_pkg::CNT_W'(lfulru_pkg::SLOTS);
    end else begin
      cap_eff = lfulru_pkg::CNT_W'(capacity);
    end
  end

  assign ram_rdata = lfulru_pkg::slot_entry_t'(ram_rdata_bits);

  // Slot RAM: key, value, use count and age rank per slot.
  lfulru_ram #(
    .WIDTH (lfulru_pkg::ENTRY_W),
    .DEPTH (lfulru_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata_bits)
  );

  lfulru_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .lookup_key  (lookup_key),
    .store_value (store_value),
    .cap_eff     (cap_eff),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .read_value  (read_value),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_wr      (ram_wr)
  );

endmodule

// ----- tb/sv/tb_lfu_cache_lru_tiebreak_top.sv -----
// Self-checking testbench for lfu_cache_lru_tiebreak_top: directed and random get/put requests
// with capacity changes, checked against a cycle-free LFU/LRU cache predictor.
// Depends on lfulru_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_lfu_cache_lru_tiebreak_top;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request taken and no reply
  localparam int SETTLE_CYCLES  = 40;    // pad after the last reply so an op's update pass can finish
  localparam int PHASE_ITEMS    = 90;
  localparam int PHASES         = 11;
  // Capacity per random phase: full, lowered below the fill, one entry, field max
  // (clamps to SLOTS), disabled, just above SLOTS, and a few in between.
  localparam bit [lfulru_pkg::CAP_W-1:0] PHASE_CAPS [PHASES] =
    '{16, 3, 1, 31, 0, 8, 17, 2, 16, 5, 16};

  localparam logic [31:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } cache_reply_t;

  // Holds a shadow copy of the cache contents and the replies still owed by the block.
  class lfu_scoreboard;
    bit                          slot_used [lfulru_pkg::SLOTS];
    bit [lfulru_pkg::KEY_W-1:0]  slot_key  [lfulru_pkg::SLOTS];
    bit [lfulru_pkg::DATA_W-1:0] slot_data [lfulru_pkg::SLOTS];
    bit [lfulru_pkg::USES_W-1:0] slot_uses [lfulru_pkg::SLOTS];
    int unsigned                 slot_age  [lfulru_pkg::SLOTS];  // 0 = most recently used
    int unsigned                 held;
    int unsigned                 capacity;
    int                          fail_count;
    int                          replies_seen;
    cache_reply_t                replies_due[$];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      held         = 0;
      capacity     = 16;
      fail_count   = 0;
      replies_seen = 0;
    endfunction

    // One more use: saturating count, then slot s becomes the most recent.
    function void count_use(int s);
      if (slot_uses[s] != '1) slot_uses[s]++;
      for (int i = 0; i < lfulru_pkg::SLOTS; i++)
        if (slot_used[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    // Applies one accepted request to the shadow cache and queues its reply.
    function void note_request(logic f, logic [31:0] k, logic [31:0] v);
      cache_reply_t r;
      int           s;
      int           victim;
      int           free_slot;
      int unsigned  eff_cap;
      eff_cap = (capacity > lfulru_pkg::SLOTS) ? lfulru_pkg::SLOTS : capacity;
      s = -1;
      for (int i = 0; i < lfulru_pkg::SLOTS; i++)
        if (s < 0 && slot_used[i] && slot_key[i] == k) s = i;
      r.hit   = (s >= 0);
      r.value = '0;
      if (f == lfulru_pkg::FUNC_GET) begin
        if (s >= 0) begin
          count_use(s);
          r.value = slot_data[s];
        end else begin
          r.value = ALL_ONES;
        end
      end else if (eff_cap != 0) begin
        if (s < 0) begin
          if (held >= eff_cap) begin
            // fewest uses goes; among equals the oldest
            victim = -1;
            for (int i = 0; i < lfulru_pkg::SLOTS; i++)
              if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                  (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
                victim = i;
            if (victim >= 0) begin
              for (int i = 0; i < lfulru_pkg::SLOTS; i++)
                if (slot_used[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
              slot_used[victim] = 1'b0;
              if (held > 0) held--;
            end
          end
          free_slot = -1;
          for (int i = 0; i < lfulru_pkg::SLOTS; i++)
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
          if (free_slot >= 0) begin
            for (int i = 0; i < lfulru_pkg::SLOTS; i++)
              if (slot_used[i]) slot_age[i]++;
            s                 = free_slot;
            slot_used[s]      = 1'b1;
            slot_key[s]       = k;
            slot_uses[s]      = '0;
            slot_age[s]       = 0;
            held++;
          end
        end
        if (s >= 0) begin
          slot_data[s] = v;
          count_use(s);
        end
      end
      replies_due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_reply(logic h, logic [31:0] v);
      cache_reply_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply %0d: no request outstanding", replies_seen));
        return;
      end
      want = replies_due.pop_front();
      if (h !== want.hit)
        report_mismatch($sformatf("reply %0d: hit %b, want %b", replies_seen, h, want.hit));
      if (v !== want.value)
        report_mismatch($sformatf("reply %0d: read_value %h, want %h",
                                  replies_seen, v, want.value));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         func;
  logic signed [31:0]           lookup_key;
  logic signed [31:0]           store_value;
  logic                         done;
  logic                         hit;
  logic signed [31:0]           read_value;
  logic                         capacity_we;
  logic [lfulru_pkg::CAP_W-1:0] capacity_in_use;

  lfu_cache_lru_tiebreak_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .lookup_key      (lookup_key),
    .store_value     (store_value),
    .done            (done),
    .hit             (hit),
    .read_value      (read_value),
    .capacity_we     (capacity_we),
    .capacity_in_use (capacity_in_use)
  );

  always #4 clk = ~clk;

  lfu_scoreboard sb = new();
  int            idle_cycles = 0;

  // Monitor: everything is sampled at the rising edge, before the block's own
  // updates land, so the scoreboard sees exactly what the block sees.
  always @(posedge clk) begin
    if (!rst) begin
      if (capacity_we) sb.capacity = capacity_in_use;
      if (start && !busy) sb.note_request(func, lookup_key, store_value);
      if (done) sb.check_reply(hit, read_value);
      // watchdog: a hung block stops both taking requests and strobing replies
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Drives one request from the falling edge and holds it until the block takes it.
  // start drops at the next falling edge; busy covers that cycle anyway.
  task automatic send_request(logic f, logic [31:0] k, logic [31:0] v);
    @(negedge clk);
    start       <= 1'b1;
    func        <= f;
    lookup_key  <= k;
    store_value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_replies();
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  // A get hit, or a put while capacity is nonzero, keeps the block busy well past
  // its reply, so pad after the last reply before touching the capacity or ending the run.
  task automatic wait_idle();
    wait_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(bit [lfulru_pkg::CAP_W-1:0] cap);
    wait_idle();
    @(negedge clk);
    capacity_we     <= 1'b1;
    capacity_in_use <= cap;
    @(negedge clk);
    capacity_we     <= 1'b0;
  endtask

  // Sender gap: sometimes hidden under busy, sometimes starting once the block
  // has gone idle so that the gap lands between ops.
  task automatic idle_gap(bit quiet);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) == 1) do @(posedge clk); while (busy);
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Random phase: keys come mostly from a pool a little larger than the capacity,
  // so hits, updates, evictions and use-count ties all happen often.
  task automatic run_phase(bit [lfulru_pkg::CAP_W-1:0] cap, int count, bit quiet);
    logic [31:0] pool[$];
    logic [31:0] k;
    logic [31:0] v;
    int          eff;
    write_capacity(cap);
    eff = (cap > lfulru_pkg::SLOTS) ? lfulru_pkg::SLOTS : cap;
    repeat (eff + 4) begin
      case ($urandom_range(0, 9))
        0:       pool.push_back(KEY_MIN);
        1:       pool.push_back(KEY_MAX);
        2, 3: begin
          // near miss: one bit away from another pool key
          if (pool.size() > 0) pool.push_back(pool[0] ^ (32'h1 << $urandom_range(0, 31)));
          else pool.push_back($urandom);
        end
        default: pool.push_back($urandom);
      endcase
    end
    repeat (count) begin
      k = ($urandom_range(0, 6) == 0) ? $urandom : pool[$urandom_range(0, pool.size() - 1)];
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = ALL_ONES;
        2:       v = KEY_MIN;
        3:       v = KEY_MAX;
        default: v = $urandom;
      endcase
      idle_gap(quiet);
      // now and then let the block drain completely before the next request
      if (!quiet && $urandom_range(0, 99) == 0) wait_replies();
      send_request(($urandom_range(0, 19) < 9) ? lfulru_pkg::FUNC_GET : lfulru_pkg::FUNC_PUT,
                   k, v);
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    func            = lfulru_pkg::FUNC_GET;
    lookup_key      = '0;
    store_value     = '0;
    capacity_we     = 1'b0;
    capacity_in_use = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty cache, key and value extremes, update of a present key,
    // a stored -1 versus a miss, disabled cache, capacity lowered below the fill.
    send_request(lfulru_pkg::FUNC_GET, 32'h0, 32'h1234_5678);
    send_request(lfulru_pkg::FUNC_PUT, KEY_MIN, KEY_MAX);
    send_request(lfulru_pkg::FUNC_PUT, KEY_MAX, KEY_MIN);
    send_request(lfulru_pkg::FUNC_PUT, 32'h0, 32'h0);
    send_request(lfulru_pkg::FUNC_PUT, ALL_ONES, ALL_ONES);
    send_request(lfulru_pkg::FUNC_GET, KEY_MIN, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, KEY_MAX, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, ALL_ONES, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, 32'h0, 32'h0);
    send_request(lfulru_pkg::FUNC_PUT, 32'h0, 32'h5A5A_5A5A);
    send_request(lfulru_pkg::FUNC_GET, 32'h0, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, 32'd12345, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, 32'h0, 32'h0);

    // disabled: puts change nothing but still report presence
    write_capacity(0);
    send_request(lfulru_pkg::FUNC_PUT, 32'd777, 32'h1);
    send_request(lfulru_pkg::FUNC_PUT, KEY_MIN, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, KEY_MIN, 32'h0);

    // one entry allowed with four held: each insert evicts exactly one
    write_capacity(1);
    send_request(lfulru_pkg::FUNC_PUT, 32'hA5A5_0001, 32'h3);
    send_request(lfulru_pkg::FUNC_GET, KEY_MAX, 32'h0);
    send_request(lfulru_pkg::FUNC_PUT, 32'hA5A5_0002, 32'h4);
    send_request(lfulru_pkg::FUNC_GET, 32'hA5A5_0001, 32'h0);
    send_request(lfulru_pkg::FUNC_GET, 32'h0, 32'h0);

    // random phases; the last two run back to back with no sender gaps
    for (int p = 0; p < PHASES; p++)
      run_phase(PHASE_CAPS[p], PHASE_ITEMS, (p >= PHASES - 2) || ($urandom_range(0, 3) == 0));

    wait_idle();
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
